// ===== sv/bcdep_pkg.sv =====
// shared types, constants and helper functions for the rtc to epoch converter
package bcdep_pkg;

	// unix seconds in one day
	localparam logic signed [34:0] SecPerDay = 35'sd86400;
	// epochs above this value count as a plausible time
	localparam logic [31:0] MinEpoch = 32'd1700000000;
	// days from 0000-03-01 to 1970-01-01
	localparam logic [20:0] EpochDayOfs = 21'd719468;

	// decoded register set after stage 1
	typedef struct packed {
		logic        bad;
		logic [11:0] yp;
		logic [3:0]  mp;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} dec_t;

	// day count and time of day after stage 2
	typedef struct packed {
		logic               bad;
		logic signed [17:0] days;
		logic [16:0]        tod;
	} days_t;

	// full signed seconds after stage 3
	typedef struct packed {
		logic               bad;
		logic signed [34:0] secs;
	} secs_t;

	// final result
	typedef struct packed {
		logic [31:0] epoch;
		logic        ok;
	} res_t;

	// bcd byte to binary, nibbles above nine pass through unchecked
	function automatic logic [7:0] bcd_dec(input logic [7:0] v);
		return ({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]};
	endfunction

	// first day of month within a march-based year
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/bcdep_ifs.sv =====
// valid/ready channel interfaces for the rtc register set and the epoch result
interface bcdep_rtc_if;
	logic       valid;
	logic       ready;
	logic [7:0] seconds_reg;
	logic [7:0] minutes_reg;
	logic [7:0] hours_reg;
	logic [7:0] days_reg;
	logic [7:0] months_reg;
	logic [7:0] years_reg;

	modport source(
		output valid, seconds_reg, minutes_reg, hours_reg, days_reg, months_reg, years_reg,
		input  ready
	);
	modport sink(
		input  valid, seconds_reg, minutes_reg, hours_reg, days_reg, months_reg, years_reg,
		output ready
	);
endinterface

interface bcdep_epoch_if;
	logic        valid;
	logic        ready;
	logic [31:0] epoch_seconds;
	logic        time_ok;

	modport source(output valid, epoch_seconds, time_ok, input ready);
	modport sink(input valid, epoch_seconds, time_ok, output ready);
endinterface

// ===== sv/bcd_rtc_to_unix_epoch.sv =====
// rtc bcd register set to unix epoch converter, four-stage pipeline
// stages: the result passes through four register stages, s1 to s4
// throughput: one register set per cycle, sustained while the output is taken
// a stall holds each full stage back to the first empty one; bubbles are squeezed out
// reset: arst_n clears all stage valid bits asynchronously, payload is not reset
module bcd_rtc_to_unix_epoch (
	input  logic                 clk,
	input  logic                 arst_n,
	bcdep_rtc_if.sink            rtc_in,
	bcdep_epoch_if.source        epoch_out
);
	import bcdep_pkg::*;

	logic  v_s1, v_s2, v_s3, v_s4;
	logic  en1, en2, en3, en4;
	dec_t  dec_c, dec_s1;
	days_t dd_c, dd_s2;
	secs_t sc_c, sc_s3;
	res_t  res_c, res_s4;

	// stage advance enables
	always_comb begin
		en4 = !v_s4 || epoch_out.ready;
		en3 = !v_s3 || en4;
		en2 = !v_s2 || en3;
		en1 = !v_s1 || en2;
	end

	assign rtc_in.ready = en1;

	// stage 1: decode
	bcdep_decode u_decode (
		.seconds_reg (rtc_in.seconds_reg),
		.minutes_reg (rtc_in.minutes_reg),
		.hours_reg   (rtc_in.hours_reg),
		.days_reg    (rtc_in.days_reg),
		.months_reg  (rtc_in.months_reg),
		.years_reg   (rtc_in.years_reg),
		.dec         (dec_c)
	);

	// stage 2: day count
	bcdep_days u_days (
		.dec (dec_s1),
		.dd  (dd_c)
	);

	// stage 3: days times seconds per day plus time of day
	always_comb begin
		sc_c.bad  = dd_s2.bad;
		sc_c.secs = {{17{dd_s2.days[17]}}, dd_s2.days} * SecPerDay +
		            $signed({18'd0, dd_s2.tod});
	end

	// stage 4: clamp and checks
	bcdep_final u_final (
		.sc  (sc_s3),
		.res (res_c)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= rtc_in.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en1) dec_s1 <= dec_c;
		if (en2) dd_s2  <= dd_c;
		if (en3) sc_s3  <= sc_c;
		if (en4) res_s4 <= res_c;
	end

	// output channel
	assign epoch_out.valid         = v_s4;
	assign epoch_out.epoch_seconds = res_s4.epoch;
	assign epoch_out.time_ok       = res_s4.ok;

`ifndef SYNTHESIS
	// a flagged time always lies above the minimum epoch
	a_valid_above_min: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_out.valid && epoch_out.time_ok |-> epoch_out.epoch_seconds > MinEpoch)
		else $error("time_ok set with epoch at or below minimum");

	// a rejected register set leaves stage 3 as a zero result
	a_bad_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && sc_s3.bad && en4 |=>
		epoch_out.epoch_seconds == 32'd0 && !epoch_out.time_ok)
		else $error("rejected fields produced a nonzero result");

	// input is held off only with every stage full and the output stalled
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rtc_in.ready |-> v_s1 && v_s2 && v_s3 && v_s4 && !epoch_out.ready)
		else $error("input stalled while the pipeline has room");
`endif

endmodule

// ===== sv/bcdep_decode.sv =====
// stage 1 logic: mask and bcd-decode the registers, range check, march-based year and month
module bcdep_decode (
	input  logic [7:0]        seconds_reg,
	input  logic [7:0]        minutes_reg,
	input  logic [7:0]        hours_reg,
	input  logic [7:0]        days_reg,
	input  logic [7:0]        months_reg,
	input  logic [7:0]        years_reg,
	output bcdep_pkg::dec_t   dec
);
	import bcdep_pkg::*;

	logic [7:0]  sec;
	logic [7:0]  mnt;
	logic [7:0]  hr;
	logic [7:0]  dy;
	logic [7:0]  mon;
	logic [7:0]  yv;
	logic [11:0] year;
	logic        early;

	// field decode with the register masks
	always_comb begin
		sec = bcd_dec({1'b0, seconds_reg[6:0]});
		mnt = bcd_dec({1'b0, minutes_reg[6:0]});
		hr  = bcd_dec({2'b00, hours_reg[5:0]});
		dy  = bcd_dec({2'b00, days_reg[5:0]});
		mon = bcd_dec({3'b000, months_reg[4:0]});
		yv  = bcd_dec(years_reg);
	end

	// century pick, year starts in march
	always_comb begin
		year  = (months_reg[7] ? 12'd1900 : 12'd2000) + {4'd0, yv};
		early = (mon <= 8'd2);
	end

	// range checks and packing
	always_comb begin
		dec.bad    = seconds_reg[7] || (sec > 8'd59) || (mnt > 8'd59) || (hr > 8'd23) ||
		             (dy == 8'd0) || (dy > 8'd31) || (mon == 8'd0) || (mon > 8'd12);
		dec.yp     = year - {11'd0, early};
		dec.mp     = early ? 4'(mon + 8'd9) : 4'(mon - 8'd3);
		dec.day    = dy[4:0];
		dec.hour   = hr[4:0];
		dec.minute = mnt[5:0];
		dec.second = sec[5:0];
	end

endmodule

// ===== sv/bcdep_days.sv =====
// stage 2 logic: days since the unix epoch and seconds within the day
module bcdep_days (
	input  bcdep_pkg::dec_t  dec,
	output bcdep_pkg::days_t dd
);
	import bcdep_pkg::*;

	logic [4:0]  q100;
	logic [2:0]  q400;
	logic [20:0] pos;
	logic [20:0] rel;

	// year over 100 and 400, the year stays within 1899..2165
	always_comb begin
		if (dec.yp >= 12'd2100) begin
			q100 = 5'd21;
		end else if (dec.yp >= 12'd2000) begin
			q100 = 5'd20;
		end else if (dec.yp >= 12'd1900) begin
			q100 = 5'd19;
		end else begin
			q100 = 5'd18;
		end
		q400 = (dec.yp >= 12'd2000) ? 3'd5 : 3'd4;
	end

	// days from civil, leap corrections folded into one sum
	always_comb begin
		pos = 21'(dec.yp) * 21'd365 + 21'(dec.yp[11:2]) + 21'(q400) +
		      21'(month_start(dec.mp)) + 21'(dec.day) - 21'd1 - 21'(q100);
		rel = pos - EpochDayOfs;
	end

	// packing with time of day
	always_comb begin
		dd.bad  = dec.bad;
		dd.days = $signed(rel[17:0]);
		dd.tod  = 17'(dec.hour) * 17'd3600 + 17'(dec.minute) * 17'd60 + 17'(dec.second);
	end

endmodule

// ===== sv/bcdep_final.sv =====
// stage 4 logic: clamp, overflow and plausibility checks
module bcdep_final (
	input  bcdep_pkg::secs_t sc,
	output bcdep_pkg::res_t  res
);
	import bcdep_pkg::*;

	logic neg;
	logic over;

	// sign and beyond-32-bit detection
	always_comb begin
		neg  = sc.secs[34];
		over = !sc.secs[34] && (sc.secs[33:32] != 2'b00);
	end

	// result select
	always_comb begin
		if (sc.bad || over) begin
			res.epoch = 32'd0;
			res.ok    = 1'b0;
		end else if (neg) begin
			res.epoch = 32'd0;
			res.ok    = 1'b0;
		end else begin
			res.epoch = sc.secs[31:0];
			res.ok    = (sc.secs[31:0] > MinEpoch);
		end
	end

endmodule
